// ===== rtl/core/mawu_pkg.sv =====
// package for the moving average filter with warm-up
// shared field widths, reset constants and divider control structs; no dependencies

package mawu_pkg;

    localparam int SAMPLE_W  = 16;  // width of one sample and of the mean
    localparam int LEN_W     = 7;   // width of the window length register
    localparam int RESET_LEN = 64;  // window length after reset, before clamping

    // request from the sequencer to the divider
    typedef struct packed {
        logic start;
    } t_div_ctrl;

    // status back from the divider
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== rtl/core/moving_average_with_warmup.sv =====
// top level of the moving average filter with warm-up
// depends on mawu_pkg, mawu_ring and mawu_div

// usage
//  input channel: i_valid / o_stall with i_sample; a request is taken at a rising
//   edge with i_valid high and o_stall low
//  output channel: o_valid / i_stall with o_mean; one result per input request,
//   held stable while i_stall is high
//  configuration: i_wr_en / i_wr_data write the window length; 0 acts as 1,
//   values above MAX_WINDOW saturate; a write restarts warm-up and clears
//   the running sum and the write slot; write only while the block is idle
//  from accept to o_valid: sum update and divider start, the divider steps
//   through all SUM_W quotient bits, then the result load
//  samples do not overlap: the bit-serial divider works on one at a time;
//   o_stall is high from accept until the result is loaded
//  a finished result waits in the output register, the next sample is taken
//   meanwhile; if the receiver still stalls when the next quotient is ready,
//   the sequencer holds it in the divider until the output register frees up
//  reset: window length 64 (clamped to MAX_WINDOW), warm-up restarts, sum zero;
//   ring entries are not cleared, during warm-up the slot being replaced is
//   known unwritten and its old value is taken as zero

module moving_average_with_warmup #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [mawu_pkg::LEN_W-1:0]     i_wr_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [mawu_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [mawu_pkg::SAMPLE_W-1:0]  o_mean
);
    import mawu_pkg::*;

    localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W   = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int CMP_W   = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;
    localparam int RST_LEN = (RESET_LEN > MAX_WINDOW) ? MAX_WINDOW : RESET_LEN;

    typedef enum logic [2:0] {
        ST_IDLE,   // waiting for a sample request
        ST_UPD,    // old sample read back, update sum and ring, start divider
        ST_DIV,    // divider running
        ST_HOLD    // quotient ready, output register still occupied
    } t_state;

    t_state              r_state, n_state;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [IDX_W-1:0]    r_slot, n_slot;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic                r_warm, n_warm;
    logic [SAMPLE_W-1:0] r_sample, n_sample;
    logic                r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0] r_mean, n_mean;

    logic [SAMPLE_W-1:0] rd_data;
    logic [SAMPLE_W-1:0] old_sample;
    logic                ring_we;
    logic [CMP_W-1:0]    cnt;
    logic                wrap;
    logic [LEN_W-1:0]    divisor;
    logic                out_free;
    t_div_ctrl           div_ctrl;
    t_div_stat           div_stat;
    logic [SUM_W-1:0]    div_quot;

    // window length from a written value: zero acts as one, saturate at the depth
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] res;
        if (v == '0) begin
            res = LEN_W'(1);
        end else if (32'(v) > MAX_WINDOW) begin
            res = LEN_W'(MAX_WINDOW);
        end else begin
            res = v;
        end
        return res;
    endfunction

    mawu_ring #(
        .DEPTH (MAX_WINDOW),
        .AW    (IDX_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_raddr (r_slot),
        .o_rdata (rd_data)
    );

    mawu_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (div_ctrl),
        .i_dividend (n_sum),
        .i_divisor  (divisor),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    always_comb begin
        // during warm-up the replaced slot was never written since the last clear
        old_sample = r_warm ? '0 : rd_data;
        cnt        = CMP_W'(r_slot) + CMP_W'(1);
        wrap       = (cnt >= CMP_W'(r_len));
        divisor    = r_warm ? cnt[LEN_W-1:0] : r_len;
        out_free   = !r_out_valid || !i_stall;

        n_state     = r_state;
        n_len       = r_len;
        n_slot      = r_slot;
        n_sum       = r_sum;
        n_warm      = r_warm;
        n_sample    = r_sample;
        n_out_valid = r_out_valid && i_stall;
        n_mean      = r_mean;
        ring_we     = 1'b0;
        div_ctrl    = '0;

        if (i_wr_en) begin
            n_len  = clamp_len(i_wr_data);
            n_slot = '0;
            n_sum  = '0;
            n_warm = 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                // ring read of the slot is issued in this cycle
                if (i_valid) begin
                    n_sample = i_sample;
                    n_state  = ST_UPD;
                end
            end
            ST_UPD: begin
                n_sum          = r_sum - SUM_W'(old_sample) + SUM_W'(r_sample);
                ring_we        = 1'b1;
                div_ctrl.start = 1'b1;
                n_slot         = wrap ? '0 : cnt[IDX_W-1:0];
                n_warm         = r_warm && !wrap;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    if (out_free) begin
                        n_mean      = div_quot[SAMPLE_W-1:0];
                        n_out_valid = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                // quotient stays in the divider until a new start
                if (out_free) begin
                    n_mean      = div_quot[SAMPLE_W-1:0];
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= LEN_W'(RST_LEN);
            r_slot      <= '0;
            r_sum       <= '0;
            r_warm      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_slot      <= n_slot;
            r_sum       <= n_sum;
            r_warm      <= n_warm;
            r_out_valid <= n_out_valid;
        end
        r_sample <= n_sample;
        r_mean   <= n_mean;
    end

    // busy from accept until the result is loaded
    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_mean  = r_mean;

endmodule

// ===== rtl/core/mawu_ring.sv =====
// sample ring memory: one write port, one registered read port
// depends on mawu_pkg for the sample width

module mawu_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [mawu_pkg::SAMPLE_W-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic [mawu_pkg::SAMPLE_W-1:0] o_rdata
);
    import mawu_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/mawu_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
// depends on mawu_pkg for the divisor width and the control structs

module mawu_div #(
    parameter int SUM_W = 22
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mawu_pkg::t_div_ctrl        i_ctrl,
    input  logic [SUM_W-1:0]           i_dividend,
    input  logic [mawu_pkg::LEN_W-1:0] i_divisor,
    output mawu_pkg::t_div_stat        o_stat,
    output logic [SUM_W-1:0]           o_quot
);
    import mawu_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] r_quo, n_quo;
    logic [LEN_W-1:0] r_rem, n_rem;
    logic [LEN_W-1:0] r_den, n_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   diff;
    logic             fits;

    always_comb begin
        trial  = {r_rem, r_quo[SUM_W-1]};
        diff   = trial - {1'b0, r_den};
        fits   = (trial >= {1'b0, r_den});
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctrl.start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_den  = i_divisor;
            n_cnt  = CNT_W'(SUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quo = {r_quo[SUM_W-2:0], fits};
            n_rem = fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;

endmodule
